### rtl/quadratic_probe_hash_table_core_assert.svh
// assertion macros for the quadratic probe hash table core
// used by rtl/quadratic_probe_hash_table_core.sv; expects clk and rst in scope
`ifndef QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// checked outside reset
`define QPHT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked during reset too
`define QPHT_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define QPHT_ASSERT(lbl, prop, msg)
`define QPHT_ASSERT_RST(lbl, prop, msg)

`endif

`endif

### rtl/qpht_pkg.sv
// shared types, codes and microcode program of the quadratic probe hash table
// no dependencies
package qpht_pkg;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // home slot is key mod 11, done as a reciprocal multiply
  localparam int unsigned HOME_MOD    = 11;
  localparam int unsigned RECIP       = 47663;
  localparam int unsigned RECIP_SHIFT = 19;
  localparam int unsigned MUL_W       = 32;
  localparam int unsigned Q_W         = MUL_W - RECIP_SHIFT;

  localparam logic [4:0] SIZE_MIN   = 5'd11;
  localparam logic [4:0] SIZE_RESET = 5'd11;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] key;
  } req_t;

  typedef struct packed {
    logic       found;
    logic [4:0] probes;
    logic [4:0] slot;
    logic       table_full;
  } rsp_t;

  // sequencer steps
  localparam int unsigned STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 3'd0;
  localparam logic [STEP_W-1:0] STEP_MUL   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_HOME  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_PROBE = 3'd3;
  localparam logic [STEP_W-1:0] STEP_EMIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_CLEAR = 3'd5;

  // jump conditions
  localparam logic [2:0] C_NEVER      = 3'd0;
  localparam logic [2:0] C_ALWAYS     = 3'd1;
  localparam logic [2:0] C_NO_REQ     = 3'd2;
  localparam logic [2:0] C_NOT_TABLE  = 3'd3;
  localparam logic [2:0] C_PROBE_MORE = 3'd4;
  localparam logic [2:0] C_OUT_BUSY   = 3'd5;

  typedef struct packed {
    logic in_rdy;
    logic mul;
    logic init;
    logic probe;
    logic clr;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic req_valid;
    logic op_table;
    logic probe_more;
    logic out_busy;
  } status_t;

  typedef struct packed {
    ctrl_t             ctrl;
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } uword_t;

  // microcode: jump to target when cond holds, else step+1 (or idle when last)
  function automatic uword_t ucode(input logic [STEP_W-1:0] s);
    uword_t w;
    w = '0;
    case (s)
      STEP_IDLE: begin
        w.ctrl.in_rdy = 1'b1;
        w.cond        = C_NO_REQ;
        w.target      = STEP_IDLE;
      end
      STEP_MUL: begin
        w.ctrl.mul = 1'b1;
        w.cond     = C_NOT_TABLE;
        w.target   = STEP_CLEAR;
      end
      STEP_HOME: begin
        w.ctrl.init = 1'b1;
        w.cond      = C_NEVER;
      end
      STEP_PROBE: begin
        w.ctrl.probe = 1'b1;
        w.cond       = C_PROBE_MORE;
        w.target     = STEP_PROBE;
      end
      STEP_EMIT: begin
        w.ctrl.emit = 1'b1;
        w.cond      = C_OUT_BUSY;
        w.target    = STEP_EMIT;
        w.last      = 1'b1;
      end
      STEP_CLEAR: begin
        w.ctrl.clr = 1'b1;
        w.cond     = C_ALWAYS;
        w.target   = STEP_EMIT;
      end
      default: begin
        w.cond   = C_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

endpackage

### rtl/quadratic_probe_hash_table_core.sv
// Open-addressing hash table with alternating quadratic probing, microcoded.
// A request makes 1 .. 2*size-1 probes; a new request is taken only in the idle step,
// after the response to the previous one has been loaded into the response register.
// One probe per cycle, set by the single read port of the key memory.
// Reset (synchronous): all slots empty at once, table_size 11, stored keys undefined.
`include "quadratic_probe_hash_table_core_assert.svh"

module quadratic_probe_hash_table_core import qpht_pkg::*; #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data
);

  // table_size is 5 bits, so no slot beyond 31 is ever reached
  localparam int unsigned MEM_DEPTH = (DEPTH < 31) ? DEPTH : 31;
  localparam int unsigned PW        = $clog2(MEM_DEPTH);
  localparam logic [4:0]  SIZE_MAX  = 5'(MEM_DEPTH);

  ctrl_t   ctrl;
  status_t status;

  logic [4:0]           table_size;
  logic [4:0]           sz;
  logic [5:0]           limit;
  logic [1:0]           op_q;
  logic [KEY_WIDTH-1:0] key_q;
  logic [15:0]          mul_in;
  logic [MUL_W-1:0]     prod;
  logic [Q_W-1:0]       q;
  logic [15:0]          rem;
  logic [3:0]           home;
  logic [4:0]           pos, pos_next;
  logic [5:0]           k, k_next;
  logic [4:0]           sq, sq_next;
  logic [4:0]           d, d_next;
  logic [5:0]           sum_sq, sum_d, sum_pos;
  logic [KEY_WIDTH-1:0] rkey;
  logic [MEM_DEPTH-1:0] slot_valid;
  logic [KEY_WIDTH-1:0] slot_key [MEM_DEPTH];
  logic                 cur_valid;
  logic                 key_hit;
  logic                 at_limit;
  logic                 done;
  logic                 key_we;
  logic                 accept;
  logic                 out_busy;
  rsp_t                 res, res_next;

  function automatic logic [4:0] mod_sz(input logic [5:0] x, input logic [4:0] m);
    logic [5:0] mx;
    mx = {1'b0, m};
    return (x >= mx) ? 5'(x - mx) : x[4:0];
  endfunction

  qpht_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  assign req_ready = ctrl.in_rdy;
  assign accept    = req_valid && ctrl.in_rdy;
  assign out_busy  = rsp_valid && !rsp_ready;

  assign status.req_valid  = req_valid;
  assign status.op_table   = (op_q == OP_INSERT) || (op_q == OP_SEARCH);
  assign status.probe_more = ctrl.probe && !done;
  assign status.out_busy   = out_busy;

  // effective size and probe bound
  always_comb begin
    if (table_size < SIZE_MIN) begin
      sz = SIZE_MIN;
    end else if (table_size > SIZE_MAX) begin
      sz = SIZE_MAX;
    end else begin
      sz = table_size;
    end
  end
  assign limit = {sz, 1'b0} - 6'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_size <= SIZE_RESET;
    end else if (cfg_we) begin
      table_size <= cfg_data;
    end
  end

  // home slot: q = floor(key / 11) by reciprocal, then key - 11*q
  assign mul_in = 16'(key_q);
  assign prod   = MUL_W'(mul_in) * MUL_W'(RECIP);
  assign rem    = mul_in - 16'(16'(q) * 16'(HOME_MOD));
  assign home   = rem[3:0];

  // probe decision
  assign cur_valid = slot_valid[pos[PW-1:0]];
  assign key_hit   = cur_valid && (rkey == key_q);
  assign at_limit  = (k == limit);

  always_comb begin
    res_next = res;
    key_we   = 1'b0;
    if (op_q == OP_INSERT) begin
      done = !cur_valid || at_limit;
    end else begin
      done = key_hit || !cur_valid || at_limit;
    end
    if (ctrl.probe && done) begin
      res_next.probes = 5'(k + 6'd1);
      if (op_q == OP_INSERT) begin
        if (!cur_valid) begin
          key_we         = 1'b1;
          res_next.found = 1'b1;
          res_next.slot  = pos + 5'd1;
        end else begin
          res_next.table_full = 1'b1;
        end
      end else if (key_hit) begin
        res_next.found = 1'b1;
        res_next.slot  = pos + 5'd1;
      end else if (cur_valid) begin
        res_next.probes = sz;
      end
    end
  end

  // next probe position, c*c mod size kept incrementally
  always_comb begin
    pos_next = pos;
    k_next   = k;
    sq_next  = sq;
    d_next   = d;
    sum_sq   = {1'b0, sq} + {1'b0, d};
    sum_d    = {1'b0, d} + 6'd2;
    sum_pos  = '0;
    if (ctrl.init) begin
      pos_next = {1'b0, home};
      k_next   = '0;
      sq_next  = '0;
      d_next   = 5'd1;
    end else if (ctrl.probe && !done) begin
      k_next = k + 6'd1;
      if (!k[0]) begin
        // next probe is on the plus side with a new square
        sq_next  = mod_sz(sum_sq, sz);
        d_next   = mod_sz(sum_d, sz);
        sum_pos  = {2'b00, home} + {1'b0, sq_next};
        pos_next = mod_sz(sum_pos, sz);
      end else begin
        sum_pos  = {2'b00, home} + {1'b0, sz} - {1'b0, sq};
        pos_next = mod_sz(sum_pos, sz);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= req.operation;
      key_q <= KEY_WIDTH'(req.key);
    end
    if (ctrl.mul) begin
      q <= prod[MUL_W-1:RECIP_SHIFT];
    end
    pos <= pos_next;
    k   <= k_next;
    sq  <= sq_next;
    d   <= d_next;
    if (accept) begin
      res <= '0;
    end else begin
      res <= res_next;
    end
  end

  // key memory, registered read at the upcoming probe position
  always_ff @(posedge clk) begin
    if (key_we) begin
      slot_key[pos[PW-1:0]] <= key_q;
    end
    rkey <= slot_key[pos_next[PW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (ctrl.clr && (op_q == OP_CLEAR)) begin
      slot_valid <= '0;
    end else if (key_we) begin
      slot_valid[pos[PW-1:0]] <= 1'b1;
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (ctrl.emit && !out_busy) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && !out_busy) begin
      rsp <= res;
    end
  end

  `QPHT_ASSERT_RST(a_reset_idle, rst |=> !rsp_valid && req_ready, "reset left block busy")
  `QPHT_ASSERT(a_accept_starts, req_valid && req_ready |=> ctrl.mul, "request not started")
  `QPHT_ASSERT(a_found_slot, rsp_valid && rsp.found |-> rsp.slot != 5'd0 && !rsp.table_full, "found without slot")
  `QPHT_ASSERT(a_store_marks, key_we |=> slot_valid[$past(pos[PW-1:0])], "stored slot not marked")
  `QPHT_ASSERT(a_probe_bound, ctrl.probe |-> k <= limit, "probe count past bound")

endmodule

### rtl/qpht_seq.sv
// microcode sequencer: step counter, program table and conditional jumps
// depends on qpht_pkg
module qpht_seq import qpht_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  uword_t            w;
  logic              take;

  assign w    = ucode(step);
  assign ctrl = w.ctrl;

  always_comb begin
    case (w.cond)
      C_ALWAYS:     take = 1'b1;
      C_NO_REQ:     take = !status.req_valid;
      C_NOT_TABLE:  take = !status.op_table;
      C_PROBE_MORE: take = status.probe_more;
      C_OUT_BUSY:   take = status.out_busy;
      default:      take = 1'b0;
    endcase
    if (take) begin
      step_next = w.target;
    end else if (w.last) begin
      step_next = STEP_IDLE;
    end else begin
      step_next = step + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule
